### hdl/tpig_pkg.sv
// Terrain patch index generator: shared types, widths, reset values and helpers.
// No dependencies; imported by every other file of the block.
package tpig_pkg;

   localparam int SIDE_LOG2_W = 3;
   localparam int INDEX_W     = 15;
   localparam int CALC_W      = 16;
   localparam int REGION_W    = 3;

   localparam logic [SIDE_LOG2_W-1:0] SIDE_LOG2_RESET = 3'd4;
   localparam logic [SIDE_LOG2_W-1:0] SIDE_LOG2_MIN   = 3'd1;

   typedef enum logic [REGION_W-1:0] {
      REGION_GRID   = 3'd0,
      REGION_SKIRT0 = 3'd1,
      REGION_SKIRT1 = 3'd2,
      REGION_SKIRT2 = 3'd3,
      REGION_SKIRT3 = 3'd4
   } region_type;

   typedef struct packed {
      logic       valid;
      region_type region;
   } snap_ctl_type;

   // x * (2^k + 1) as a shift and add
   function automatic logic [CALC_W-1:0] mul_side(input logic [CALC_W-1:0] x,
                                                 input logic [SIDE_LOG2_W-1:0] k);
      return (x << k) + x;
   endfunction

endpackage

### hdl/tpig_channels.sv
// Terrain patch index generator: valid/ready channel interfaces.
// Depends on tpig_pkg for payload widths.
interface tpig_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface tpig_rsp_if import tpig_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [INDEX_W-1:0]  index0;
   logic [INDEX_W-1:0]  index1;
   logic [INDEX_W-1:0]  index2;
   logic [INDEX_W-1:0]  index3;
   logic [INDEX_W-1:0]  index4;
   logic [INDEX_W-1:0]  index5;
   logic [REGION_W-1:0] region;
   logic                mesh_end;

   modport source (output valid, output index0, output index1, output index2,
                   output index3, output index4, output index5, output region,
                   output mesh_end, input ready);
   modport sink   (input valid, input index0, input index1, input index2,
                   input index3, input index4, input index5, input region,
                   input mesh_end, output ready);
endinterface

interface tpig_csr_if import tpig_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [SIDE_LOG2_W-1:0] side_log2;

   modport source (output valid, output side_log2, input ready);
   modport sink   (input valid, input side_log2, output ready);
endinterface

### hdl/tpig_seq.sv
// Terrain patch index generator: region/row/column counters and input stage.
// Depends on tpig_pkg and tpig_req_if.
module tpig_seq import tpig_pkg::*; #(
   parameter int CNT_W = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [SIDE_LOG2_W-1:0] side_log2_eff,
   input  logic                   clear,
   tpig_req_if.sink               req_port,
   input  logic                   snap_ready,
   output snap_ctl_type           snap_ctl,
   output logic [CNT_W-1:0]       snap_row,
   output logic [CNT_W-1:0]       snap_col
);

   region_type       region_ff, region_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0] col_ff, col_in;
   snap_ctl_type     snap_ctl_ff, snap_ctl_in;
   logic [CNT_W-1:0] snap_row_ff, snap_row_in;
   logic [CNT_W-1:0] snap_col_ff, snap_col_in;

   logic [CNT_W:0]   side_w;
   logic [CNT_W-1:0] last_w;
   region_type       cur_region;
   logic [CNT_W-1:0] cur_row;
   logic [CNT_W-1:0] cur_col;
   logic             accept;

   assign side_w = (CNT_W+1)'(1) << side_log2_eff;
   assign last_w = CNT_W'(side_w - (CNT_W+1)'(1));

   assign req_port.ready = !snap_ctl_ff.valid || snap_ready;
   assign accept         = req_port.valid && req_port.ready;

   assign cur_region = req_port.restart ? REGION_GRID : region_ff;
   assign cur_row    = req_port.restart ? '0 : row_ff;
   assign cur_col    = req_port.restart ? '0 : col_ff;

   always_comb begin
      region_in = region_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      if (clear) begin
         region_in = REGION_GRID;
         row_in    = '0;
         col_in    = '0;
      end else if (accept) begin
         region_in = cur_region;
         row_in    = cur_row;
         col_in    = cur_col + CNT_W'(1);
         if (cur_col >= last_w) begin
            col_in = '0;
            if (cur_region == REGION_GRID) begin
               if (cur_row >= last_w) begin
                  row_in    = '0;
                  region_in = REGION_SKIRT0;
               end else begin
                  row_in = cur_row + CNT_W'(1);
               end
            end else if (cur_region == REGION_SKIRT3) begin
               region_in = REGION_GRID;
            end else begin
               region_in = region_type'(cur_region + REGION_W'(1));
            end
         end
      end
   end

   always_comb begin
      snap_ctl_in = snap_ctl_ff;
      snap_row_in = snap_row_ff;
      snap_col_in = snap_col_ff;
      if (accept) begin
         snap_ctl_in.valid  = 1'b1;
         snap_ctl_in.region = cur_region;
         snap_row_in        = cur_row;
         snap_col_in        = cur_col;
      end else if (snap_ready) begin
         snap_ctl_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff         <= REGION_GRID;
         row_ff            <= '0;
         col_ff            <= '0;
         snap_ctl_ff.valid <= 1'b0;
         snap_ctl_ff.region <= REGION_GRID;
      end else begin
         region_ff   <= region_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         snap_ctl_ff <= snap_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_row_ff <= snap_row_in;
      snap_col_ff <= snap_col_in;
   end

   assign snap_ctl = snap_ctl_ff;
   assign snap_row = snap_row_ff;
   assign snap_col = snap_col_ff;

   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      col_ff <= last_w)
      else $error("column counter beyond last quad");

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      row_ff <= last_w)
      else $error("row counter beyond last quad");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_port.restart |=>
         snap_col_ff == '0 && snap_row_ff == '0 && snap_ctl_ff.region == REGION_GRID)
      else $error("restart did not start at first quad");

   a_skirt_row: assert property (@(posedge clock) disable iff (reset)
      region_ff != REGION_GRID |-> row_ff == '0)
      else $error("row counter not zero in skirt");

endmodule

### hdl/tpig_calc.sv
// Terrain patch index generator: index arithmetic and result register.
// Depends on tpig_pkg and tpig_rsp_if.
module tpig_calc import tpig_pkg::*; #(
   parameter int CNT_W = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [SIDE_LOG2_W-1:0] side_log2_eff,
   input  snap_ctl_type           snap_ctl,
   input  logic [CNT_W-1:0]       snap_row,
   input  logic [CNT_W-1:0]       snap_col,
   output logic                   snap_ready,
   tpig_rsp_if.source             rsp_port
);

   logic [CALC_W-1:0] side_v, nn, row_v, col_v, last_v, skirt_sel;
   logic [CALC_W-1:0] a_v, c_v, ea_v, eb_v, si_v, sn_v;
   logic [CALC_W-1:0] idx_v [6];
   logic              end_v;

   logic               valid_ff, valid_in;
   logic [INDEX_W-1:0] idx_ff [6];
   logic [INDEX_W-1:0] idx_in [6];
   region_type         region_ff, region_in;
   logic               end_ff, end_in;

   assign side_v    = CALC_W'(1) << side_log2_eff;
   assign last_v    = side_v - CALC_W'(1);
   assign nn        = mul_side(side_v + CALC_W'(1), side_log2_eff);
   assign row_v     = CALC_W'(snap_row);
   assign col_v     = CALC_W'(snap_col);
   assign skirt_sel = CALC_W'(snap_ctl.region) - CALC_W'(1);

   assign a_v  = mul_side(row_v, side_log2_eff) + col_v;
   assign c_v  = a_v + side_v + CALC_W'(1);
   assign si_v = nn + (skirt_sel << side_log2_eff) + col_v;

   always_comb begin
      ea_v = col_v;
      eb_v = col_v + CALC_W'(1);
      unique case (snap_ctl.region)
         REGION_SKIRT1: begin
            ea_v = mul_side(col_v + CALC_W'(1), side_log2_eff) - CALC_W'(1);
            eb_v = mul_side(col_v + CALC_W'(2), side_log2_eff) - CALC_W'(1);
         end
         REGION_SKIRT2: begin
            ea_v = nn - CALC_W'(1) - col_v;
            eb_v = nn - CALC_W'(2) - col_v;
         end
         REGION_SKIRT3: begin
            ea_v = mul_side(side_v - col_v, side_log2_eff);
            eb_v = mul_side(last_v - col_v, side_log2_eff);
         end
         default: begin
            ea_v = col_v;
            eb_v = col_v + CALC_W'(1);
         end
      endcase
   end

   always_comb begin
      end_v = (snap_ctl.region == REGION_SKIRT3) && (col_v >= last_v);
      sn_v  = end_v ? nn : si_v + CALC_W'(1);
      if (snap_ctl.region == REGION_GRID) begin
         idx_v[0] = a_v;
         idx_v[1] = a_v + CALC_W'(1);
         idx_v[2] = c_v + CALC_W'(1);
         idx_v[3] = a_v;
         idx_v[4] = c_v + CALC_W'(1);
         idx_v[5] = c_v;
      end else begin
         idx_v[0] = ea_v;
         idx_v[1] = si_v;
         idx_v[2] = eb_v;
         idx_v[3] = eb_v;
         idx_v[4] = si_v;
         idx_v[5] = sn_v;
      end
   end

   assign snap_ready = !valid_ff || rsp_port.ready;

   always_comb begin
      valid_in  = valid_ff;
      idx_in    = idx_ff;
      region_in = region_ff;
      end_in    = end_ff;
      if (snap_ctl.valid && snap_ready) begin
         valid_in  = 1'b1;
         region_in = snap_ctl.region;
         end_in    = end_v;
         for (int i = 0; i < 6; i++) begin
            idx_in[i] = idx_v[i][INDEX_W-1:0];
         end
      end else if (rsp_port.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      region_ff <= region_in;
      end_ff    <= end_in;
   end

   assign rsp_port.valid    = valid_ff;
   assign rsp_port.index0   = idx_ff[0];
   assign rsp_port.index1   = idx_ff[1];
   assign rsp_port.index2   = idx_ff[2];
   assign rsp_port.index3   = idx_ff[3];
   assign rsp_port.index4   = idx_ff[4];
   assign rsp_port.index5   = idx_ff[5];
   assign rsp_port.region   = region_ff;
   assign rsp_port.mesh_end = end_ff;

   a_end_region: assert property (@(posedge clock) disable iff (reset)
      valid_ff && end_ff |-> region_ff == REGION_SKIRT3)
      else $error("mesh end outside last skirt side");

   a_load: assert property (@(posedge clock) disable iff (reset)
      snap_ctl.valid && snap_ready |=> valid_ff)
      else $error("transaction lost in result stage");

   a_grid_shape: assert property (@(posedge clock) disable iff (reset)
      valid_ff && region_ff == REGION_GRID |->
         idx_ff[0] == idx_ff[3] && idx_ff[2] == idx_ff[4])
      else $error("grid quad triangles do not share diagonal");

endmodule

### hdl/terrain_patch_index_generator_unit.sv
// Channel  Dir  Payload                                   Transfer
// req      in   restart                                   valid && ready
// rsp      out  index0..index5, region, mesh_end          valid && ready
// csr      in   side_log2 (grid side 2^k+1)               valid && ready
//
// One quad per cycle sustained while rsp is ready; two register stages: the counter
// snapshot in tpig_seq and the result register in tpig_calc. Counters advance in
// tpig_seq, indices are shift/add from the counter snapshot in tpig_calc.
// Reset clears counters and the pipeline; side_log2 returns to 4.
// A stalled rsp holds its result; req ready drops only when both stages are full.
// Top level of the terrain patch index generator; depends on tpig_pkg, the channel
// interfaces, tpig_seq and tpig_calc.
module terrain_patch_index_generator_unit import tpig_pkg::*; #(
   parameter int MAX_SIDE_LOG2 = 7
) (
   input  logic       clock,
   input  logic       reset,
   tpig_req_if.sink   req_port,
   tpig_rsp_if.source rsp_port,
   tpig_csr_if.sink   csr_port
);

   logic [SIDE_LOG2_W-1:0] side_log2_ff, side_log2_in;
   logic [SIDE_LOG2_W-1:0] side_log2_eff;
   logic                   csr_write;
   snap_ctl_type           snap_ctl;
   logic [MAX_SIDE_LOG2-1:0] snap_row;
   logic [MAX_SIDE_LOG2-1:0] snap_col;
   logic                   snap_ready;

   assign csr_port.ready = 1'b1;
   assign csr_write      = csr_port.valid && csr_port.ready;
   assign side_log2_in   = csr_write ? csr_port.side_log2 : side_log2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_log2_ff <= SIDE_LOG2_RESET;
      end else begin
         side_log2_ff <= side_log2_in;
      end
   end

   always_comb begin
      priority if (side_log2_ff < SIDE_LOG2_MIN) begin
         side_log2_eff = SIDE_LOG2_MIN;
      end else if (side_log2_ff > SIDE_LOG2_W'(MAX_SIDE_LOG2)) begin
         side_log2_eff = SIDE_LOG2_W'(MAX_SIDE_LOG2);
      end else begin
         side_log2_eff = side_log2_ff;
      end
   end

   tpig_seq #(
      .CNT_W(MAX_SIDE_LOG2)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .side_log2_eff (side_log2_eff),
      .clear         (csr_write),
      .req_port      (req_port),
      .snap_ready    (snap_ready),
      .snap_ctl      (snap_ctl),
      .snap_row      (snap_row),
      .snap_col      (snap_col)
   );

   tpig_calc #(
      .CNT_W(MAX_SIDE_LOG2)
   ) u_calc (
      .clock         (clock),
      .reset         (reset),
      .side_log2_eff (side_log2_eff),
      .snap_ctl      (snap_ctl),
      .snap_row      (snap_row),
      .snap_col      (snap_col),
      .snap_ready    (snap_ready),
      .rsp_port      (rsp_port)
   );

endmodule
